FILE: sv/cau_pkg.sv
// Shared constants, types and mode codes for the complex arithmetic unit.
`timescale 1ns / 1ps
`default_nettype none
package cau_pkg;
    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int PROD_W     = 2 * DATA_WIDTH;
    localparam int SUM_W      = PROD_W + 1;
    localparam int WORK_W     = SUM_W + FRAC_BITS + DATA_WIDTH;
    localparam int S_TDATA_W  = ((2 + 4 * DATA_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((2 * DATA_WIDTH + 2 + 7) / 8) * 8;

    typedef enum logic [1:0] {
        MODE_ADD = 2'd0,
        MODE_SUB = 2'd1,
        MODE_MUL = 2'd2,
        MODE_DIV = 2'd3
    } mode_t;

    // sign and magnitude of both parts, ready for the divider
    typedef struct packed {
        logic              valid;
        logic              div;
        logic              dz;
        logic              neg_r;
        logic              neg_i;
        logic [SUM_W-1:0]  mag_r;
        logic [SUM_W-1:0]  mag_i;
        logic [PROD_W-1:0] den;
    } item_t;

    // one divider stage; rem carries the plain magnitude outside divide mode
    typedef struct packed {
        logic                  valid;
        logic                  div;
        logic                  dz;
        logic                  neg_r;
        logic                  neg_i;
        logic                  big_r;
        logic                  big_i;
        logic [WORK_W-1:0]     rem_r;
        logic [WORK_W-1:0]     rem_i;
        logic [DATA_WIDTH-1:0] q_r;
        logic [DATA_WIDTH-1:0] q_i;
        logic [PROD_W-1:0]     den;
    } div_t;
endpackage
`default_nettype wire

FILE: sv/complex_arithmetic_unit.sv
// Top level: stream ports, front stages, divider chain, saturation and output word.
// Pipeline: 4 front stages, 33 divider stages and 1 output stage from input word to result
// word, the same for every mode.
// Throughput: one word per cycle; the whole pipeline holds while the output word waits.
// Reset: aresetn synchronous, active low, clears all valid bits; data is not reset.
`timescale 1ns / 1ps
`default_nettype none
module complex_arithmetic_unit (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // mode, left_real, left_imag, right_real, right_imag, zero pad
    input  wire logic [cau_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // res_real, res_imag, div_by_zero, overflow, zero pad
    output logic [cau_pkg::M_TDATA_W-1:0]        m_tdata
);
    import cau_pkg::*;

    localparam logic [SUM_W-1:0] MAX_POS = SUM_W'({1'b0, {(DATA_WIDTH-1){1'b1}}});
    localparam logic [SUM_W-1:0] MAX_NEG = SUM_W'({1'b1, {(DATA_WIDTH-1){1'b0}}});

    logic                  en;
    item_t                 item;
    div_t                  last;

    logic                  out_valid_reg;
    logic [DATA_WIDTH-1:0] res_r_reg, res_i_reg, res_r_next, res_i_next;
    logic                  dz_reg, ovf_reg, dz_next, ovf_next;
    logic                  ovf_r, ovf_i;

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    cau_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_tvalid),
        .in_mode  (s_tdata[1:0]),
        .in_lr    (s_tdata[2+DATA_WIDTH-1:2]),
        .in_li    (s_tdata[2+2*DATA_WIDTH-1:2+DATA_WIDTH]),
        .in_rr    (s_tdata[2+3*DATA_WIDTH-1:2+2*DATA_WIDTH]),
        .in_ri    (s_tdata[2+4*DATA_WIDTH-1:2+3*DATA_WIDTH]),
        .item     (item)
    );

    cau_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .item    (item),
        .last    (last)
    );

    // returns {overflow, value}
    function automatic logic [DATA_WIDTH:0] saturate(input logic neg, input logic big,
                                                     input logic [SUM_W-1:0] m);
        logic [DATA_WIDTH:0] r;
        if (!neg) begin
            if (big || m > MAX_POS) r = {1'b1, MAX_POS[DATA_WIDTH-1:0]};
            else                    r = {1'b0, m[DATA_WIDTH-1:0]};
        end else begin
            if (big || m > MAX_NEG) r = {1'b1, MAX_NEG[DATA_WIDTH-1:0]};
            else                    r = {1'b0, -m[DATA_WIDTH-1:0]};
        end
        return r;
    endfunction

    always_comb begin
        if (last.div && last.dz) begin
            {ovf_r, res_r_next} = '0;
            {ovf_i, res_i_next} = '0;
        end else if (last.div) begin
            {ovf_r, res_r_next} = saturate(last.neg_r, last.big_r, SUM_W'(last.q_r));
            {ovf_i, res_i_next} = saturate(last.neg_i, last.big_i, SUM_W'(last.q_i));
        end else begin
            {ovf_r, res_r_next} = saturate(last.neg_r, 1'b0, last.rem_r[SUM_W-1:0]);
            {ovf_i, res_i_next} = saturate(last.neg_i, 1'b0, last.rem_i[SUM_W-1:0]);
        end
        dz_next  = last.div && last.dz;
        ovf_next = ovf_r || ovf_i;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= last.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_r_reg <= res_r_next;
            res_i_reg <= res_i_next;
            dz_reg    <= dz_next;
            ovf_reg   <= ovf_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'({ovf_reg, dz_reg, res_i_reg, res_r_reg});

    a_dz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && dz_reg |-> res_r_reg == '0 && res_i_reg == '0 && !ovf_reg)
        else $error("zero divisor result not cleared");

    a_ovf_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && ovf_reg |-> res_r_reg == MAX_POS[DATA_WIDTH-1:0]
            || res_r_reg == MAX_NEG[DATA_WIDTH-1:0]
            || res_i_reg == MAX_POS[DATA_WIDTH-1:0]
            || res_i_reg == MAX_NEG[DATA_WIDTH-1:0])
        else $error("overflow without a saturated part");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(last.valid) && $stable(res_r_next))
        else $error("pipeline moved during stall");
endmodule
`default_nettype wire

FILE: sv/cau_front.sv
// Input register, multipliers, sums and sign/magnitude split (four stages).
`timescale 1ns / 1ps
`default_nettype none
module cau_front (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            en,
    input  wire logic                            in_valid,
    input  wire logic [1:0]                      in_mode,
    input  wire logic [cau_pkg::DATA_WIDTH-1:0]  in_lr,
    input  wire logic [cau_pkg::DATA_WIDTH-1:0]  in_li,
    input  wire logic [cau_pkg::DATA_WIDTH-1:0]  in_rr,
    input  wire logic [cau_pkg::DATA_WIDTH-1:0]  in_ri,
    output cau_pkg::item_t                       item
);
    import cau_pkg::*;

    logic                         a_valid_reg;
    mode_t                        a_mode_reg;
    logic signed [DATA_WIDTH-1:0] a_lr_reg, a_li_reg, a_rr_reg, a_ri_reg;

    logic                         b_valid_reg;
    mode_t                        b_mode_reg;
    logic signed [PROD_W-1:0]     b_p_rr_reg, b_p_ii_reg, b_p_ri_reg, b_p_ir_reg;
    logic signed [PROD_W-1:0]     b_d_rr_reg, b_d_ii_reg;
    logic signed [DATA_WIDTH:0]   b_sr_reg, b_si_reg;
    logic signed [PROD_W-1:0]     b_p_rr_next, b_p_ii_next, b_p_ri_next, b_p_ir_next;
    logic signed [PROD_W-1:0]     b_d_rr_next, b_d_ii_next;
    logic signed [DATA_WIDTH:0]   b_sr_next, b_si_next;

    logic                         c_valid_reg;
    mode_t                        c_mode_reg;
    logic [SUM_W-1:0]             c_vr_reg, c_vi_reg;
    logic [PROD_W-1:0]            c_den_reg;
    logic [SUM_W-1:0]             c_vr_next, c_vi_next;
    logic [PROD_W-1:0]            c_den_next;

    item_t                        item_reg, item_next;
    logic [SUM_W-1:0]             abs_r, abs_i;

    always_comb begin
        b_p_rr_next = a_lr_reg * a_rr_reg;
        b_p_ii_next = a_li_reg * a_ri_reg;
        b_p_ri_next = a_lr_reg * a_ri_reg;
        b_p_ir_next = a_li_reg * a_rr_reg;
        b_d_rr_next = a_rr_reg * a_rr_reg;
        b_d_ii_next = a_ri_reg * a_ri_reg;
        if (a_mode_reg == MODE_SUB) begin
            b_sr_next = {a_lr_reg[DATA_WIDTH-1], a_lr_reg} - {a_rr_reg[DATA_WIDTH-1], a_rr_reg};
            b_si_next = {a_li_reg[DATA_WIDTH-1], a_li_reg} - {a_ri_reg[DATA_WIDTH-1], a_ri_reg};
        end else begin
            b_sr_next = {a_lr_reg[DATA_WIDTH-1], a_lr_reg} + {a_rr_reg[DATA_WIDTH-1], a_rr_reg};
            b_si_next = {a_li_reg[DATA_WIDTH-1], a_li_reg} + {a_ri_reg[DATA_WIDTH-1], a_ri_reg};
        end
    end

    always_comb begin
        c_den_next = b_d_rr_reg + b_d_ii_reg;
        case (b_mode_reg)
            MODE_MUL: begin
                c_vr_next = {b_p_rr_reg[PROD_W-1], b_p_rr_reg}
                          - {b_p_ii_reg[PROD_W-1], b_p_ii_reg};
                c_vi_next = {b_p_ri_reg[PROD_W-1], b_p_ri_reg}
                          + {b_p_ir_reg[PROD_W-1], b_p_ir_reg};
            end
            MODE_DIV: begin
                c_vr_next = {b_p_rr_reg[PROD_W-1], b_p_rr_reg}
                          + {b_p_ii_reg[PROD_W-1], b_p_ii_reg};
                c_vi_next = {b_p_ir_reg[PROD_W-1], b_p_ir_reg}
                          - {b_p_ri_reg[PROD_W-1], b_p_ri_reg};
            end
            default: begin
                c_vr_next = {{(SUM_W-DATA_WIDTH-1){b_sr_reg[DATA_WIDTH]}}, b_sr_reg};
                c_vi_next = {{(SUM_W-DATA_WIDTH-1){b_si_reg[DATA_WIDTH]}}, b_si_reg};
            end
        endcase
    end

    // magnitude first, then shift, so products truncate toward zero
    always_comb begin
        abs_r = c_vr_reg[SUM_W-1] ? (~c_vr_reg + SUM_W'(1)) : c_vr_reg;
        abs_i = c_vi_reg[SUM_W-1] ? (~c_vi_reg + SUM_W'(1)) : c_vi_reg;
        item_next.valid = c_valid_reg;
        item_next.div   = (c_mode_reg == MODE_DIV);
        item_next.dz    = (c_mode_reg == MODE_DIV) && (c_den_reg == '0);
        item_next.neg_r = c_vr_reg[SUM_W-1];
        item_next.neg_i = c_vi_reg[SUM_W-1];
        item_next.mag_r = (c_mode_reg == MODE_MUL) ? (abs_r >> FRAC_BITS) : abs_r;
        item_next.mag_i = (c_mode_reg == MODE_MUL) ? (abs_i >> FRAC_BITS) : abs_i;
        item_next.den   = c_den_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg    <= 1'b0;
            b_valid_reg    <= 1'b0;
            c_valid_reg    <= 1'b0;
            item_reg.valid <= 1'b0;
        end else if (en) begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            item_reg    <= item_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_mode_reg <= mode_t'(in_mode);
            a_lr_reg   <= in_lr;
            a_li_reg   <= in_li;
            a_rr_reg   <= in_rr;
            a_ri_reg   <= in_ri;
            b_mode_reg <= a_mode_reg;
            b_p_rr_reg <= b_p_rr_next;
            b_p_ii_reg <= b_p_ii_next;
            b_p_ri_reg <= b_p_ri_next;
            b_p_ir_reg <= b_p_ir_next;
            b_d_rr_reg <= b_d_rr_next;
            b_d_ii_reg <= b_d_ii_next;
            b_sr_reg   <= b_sr_next;
            b_si_reg   <= b_si_next;
            c_mode_reg <= b_mode_reg;
            c_vr_reg   <= c_vr_next;
            c_vi_reg   <= c_vi_next;
            c_den_reg  <= c_den_next;
        end
    end

    assign item = item_reg;
endmodule
`default_nettype wire

FILE: sv/cau_div.sv
// Pipelined restoring divider: range check stage, then one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module cau_div (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          en,
    input  wire cau_pkg::item_t item,
    output cau_pkg::div_t      last
);
    import cau_pkg::*;

    div_t st_reg  [0:DATA_WIDTH];
    div_t st_next [0:DATA_WIDTH];

    logic [WORK_W-1:0] num_r, num_i, lim;

    // quotient of 2^DATA_WIDTH or more saturates anyway: flag it so the output stage ignores the quotient
    always_comb begin
        num_r = WORK_W'(item.mag_r) << FRAC_BITS;
        num_i = WORK_W'(item.mag_i) << FRAC_BITS;
        lim   = WORK_W'(item.den) << DATA_WIDTH;
        st_next[0].valid = item.valid;
        st_next[0].div   = item.div;
        st_next[0].dz    = item.dz;
        st_next[0].neg_r = item.neg_r;
        st_next[0].neg_i = item.neg_i;
        st_next[0].big_r = item.div && (num_r >= lim);
        st_next[0].big_i = item.div && (num_i >= lim);
        st_next[0].rem_r = item.div ? num_r : WORK_W'(item.mag_r);
        st_next[0].rem_i = item.div ? num_i : WORK_W'(item.mag_i);
        st_next[0].q_r   = '0;
        st_next[0].q_i   = '0;
        st_next[0].den   = item.den;
    end

    for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_step
        localparam int SH = DATA_WIDTH - 1 - k;
        logic [WORK_W-1:0] dsh;
        logic [WORK_W:0]   diff_r, diff_i;
        logic              take_r, take_i;

        always_comb begin
            dsh    = WORK_W'(st_reg[k].den) << SH;
            diff_r = {1'b0, st_reg[k].rem_r} - {1'b0, dsh};
            diff_i = {1'b0, st_reg[k].rem_i} - {1'b0, dsh};
            take_r = st_reg[k].div && !diff_r[WORK_W];
            take_i = st_reg[k].div && !diff_i[WORK_W];
            st_next[k+1]         = st_reg[k];
            st_next[k+1].rem_r   = take_r ? diff_r[WORK_W-1:0] : st_reg[k].rem_r;
            st_next[k+1].rem_i   = take_i ? diff_i[WORK_W-1:0] : st_reg[k].rem_i;
            st_next[k+1].q_r[SH] = take_r;
            st_next[k+1].q_i[SH] = take_i;
        end
    end

    for (genvar s = 0; s <= DATA_WIDTH; s++) begin : g_reg
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                st_reg[s].valid <= 1'b0;
            end else if (en) begin
                st_reg[s] <= st_next[s];
            end
        end
    end

    assign last = st_reg[DATA_WIDTH];
endmodule
`default_nettype wire
